### design/ast_pkg.sv
// ----------------------------------------------------------------------------
// ast_pkg
// Shared widths, token kind codes, character codes and the token beat type
// for the assembly source tokenizer.
// ----------------------------------------------------------------------------
package ast_pkg;

  localparam int POSITION_BITS = 16;
  localparam int VALUE_BITS    = 32;
  localparam int KIND_BITS     = 4;
  localparam int CHAR_BITS     = 8;

  // Token kinds.
  localparam logic [KIND_BITS-1:0] K_NAME     = 4'd0;
  localparam logic [KIND_BITS-1:0] K_NUMBER   = 4'd1;
  localparam logic [KIND_BITS-1:0] K_COLON    = 4'd2;
  localparam logic [KIND_BITS-1:0] K_COMMA    = 4'd3;
  localparam logic [KIND_BITS-1:0] K_LBRACKET = 4'd4;
  localparam logic [KIND_BITS-1:0] K_RBRACKET = 4'd5;
  localparam logic [KIND_BITS-1:0] K_NEWLINE  = 4'd6;
  localparam logic [KIND_BITS-1:0] K_ERROR    = 4'd7;
  localparam logic [KIND_BITS-1:0] K_END      = 4'd8;

  // Character codes.
  localparam logic [CHAR_BITS-1:0] C_EOT       = 8'h00;
  localparam logic [CHAR_BITS-1:0] C_TAB       = 8'h09;
  localparam logic [CHAR_BITS-1:0] C_NEWLINE   = 8'h0A;
  localparam logic [CHAR_BITS-1:0] C_VTAB      = 8'h0B;
  localparam logic [CHAR_BITS-1:0] C_FORMFEED  = 8'h0C;
  localparam logic [CHAR_BITS-1:0] C_CR        = 8'h0D;
  localparam logic [CHAR_BITS-1:0] C_SPACE     = 8'h20;
  localparam logic [CHAR_BITS-1:0] C_COMMA     = 8'h2C;
  localparam logic [CHAR_BITS-1:0] C_DOT       = 8'h2E;
  localparam logic [CHAR_BITS-1:0] C_DIGIT_0   = 8'h30;
  localparam logic [CHAR_BITS-1:0] C_DIGIT_9   = 8'h39;
  localparam logic [CHAR_BITS-1:0] C_COLON     = 8'h3A;
  localparam logic [CHAR_BITS-1:0] C_SEMICOLON = 8'h3B;
  localparam logic [CHAR_BITS-1:0] C_UPPER_A   = 8'h41;
  localparam logic [CHAR_BITS-1:0] C_UPPER_Z   = 8'h5A;
  localparam logic [CHAR_BITS-1:0] C_LBRACKET  = 8'h5B;
  localparam logic [CHAR_BITS-1:0] C_RBRACKET  = 8'h5D;
  localparam logic [CHAR_BITS-1:0] C_UNDERSCORE = 8'h5F;
  localparam logic [CHAR_BITS-1:0] C_LOWER_A   = 8'h61;
  localparam logic [CHAR_BITS-1:0] C_LOWER_Z   = 8'h7A;

  // One token beat.
  typedef struct packed {
    logic [KIND_BITS-1:0]     kind;
    logic [POSITION_BITS-1:0] start_res;
    logic [POSITION_BITS-1:0] length;
    logic [VALUE_BITS-1:0]    value;
    logic                     last_of_run;
  } token_t;

endpackage

### design/ast_char_if.sv
// ----------------------------------------------------------------------------
// ast_char_if
// Valid/ready channel that carries one source character per beat.
// ----------------------------------------------------------------------------
interface ast_char_if;
  logic                          valid;
  logic                          ready;
  logic [ast_pkg::CHAR_BITS-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

### design/ast_token_if.sv
// ----------------------------------------------------------------------------
// ast_token_if
// Valid/ready channel that carries one token per beat.
// ----------------------------------------------------------------------------
interface ast_token_if;
  logic                              valid;
  logic                              ready;
  logic [ast_pkg::KIND_BITS-1:0]     kind;
  logic [ast_pkg::POSITION_BITS-1:0] start_res;
  logic [ast_pkg::POSITION_BITS-1:0] length;
  logic [ast_pkg::VALUE_BITS-1:0]    value;
  logic                              last_of_run;

  modport source (output valid, output kind, output start_res, output length,
                  output value, output last_of_run, input ready);
  modport sink   (input valid, input kind, input start_res, input length,
                  input value, input last_of_run, output ready);
endinterface

### design/assembly_source_tokenizer.sv
// ----------------------------------------------------------------------------
// assembly_source_tokenizer
// Streams source characters in and assembly tokens out, one character a beat.
// ----------------------------------------------------------------------------
// Usage:
//   chars  : one source byte per beat; a zero byte ends the text and returns
//            all scanning state to its start, ready for the next text.
//   tokens : one token per beat; last_of_run marks the final token that one
//            character caused (a character causes zero, one or two tokens).
// Timing:
//   A character is scanned in the cycle it is accepted and its tokens are
//   written into a four-beat output queue, so the first token is offered on
//   tokens the cycle after acceptance if the queue held no earlier tokens.
//   chars accepts one character per cycle while the queue holds at most two
//   beats. A two-token character needs an output beat for each, so the
//   port's single beat per cycle, when tokens.ready is high, sets the rate.
// Reset:
//   rst (synchronous) empties the queue and clears all scanning state.
// Stall:
//   When the receiver holds tokens.ready low the queue fills and chars.ready
//   drops; no token is lost or repeated.
// ----------------------------------------------------------------------------
module assembly_source_tokenizer (
  input  logic               clk,
  input  logic               rst,
  ast_char_if.sink           chars,
  ast_token_if.source        tokens
);

  localparam int PB        = ast_pkg::POSITION_BITS;
  localparam int VB        = ast_pkg::VALUE_BITS;
  localparam int PRODB     = VB + 4;
  localparam int QDEPTH    = 4;
  localparam int QPTRB     = $clog2(QDEPTH);
  localparam int QCNTB     = $clog2(QDEPTH + 1);
  localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};
  localparam logic [VB-1:0] VAL_MAX = {VB{1'b1}};

  // Scanning state.
  logic [PB-1:0] position, position_next;
  logic [PB-1:0] word_start, word_start_next;
  logic [PB-1:0] word_length, word_length_next;
  logic          all_digits, all_digits_next;
  logic [VB-1:0] number_value, number_value_next;
  logic          in_comment, in_comment_next;
  logic          halted_on_error, halted_on_error_next;

  // Output queue.
  ast_pkg::token_t queue [QDEPTH];
  logic [QPTRB-1:0] wr_ptr, rd_ptr;
  logic [QCNTB-1:0] count;

  logic accept, pop;
  logic [ast_pkg::CHAR_BITS-1:0] c;
  logic is_digit, is_word;
  logic word_emit, tok_emit;
  ast_pkg::token_t word_tok, single_tok, entry0, entry1;
  logic [1:0] n_wr;
  logic [PRODB-1:0] prod;
  logic [3:0] digit;

  assign chars.ready = (count <= QCNTB'(QDEPTH - 2));
  assign accept      = chars.valid && chars.ready;
  assign pop         = tokens.valid && tokens.ready;
  assign c           = chars.ch;

  // Character classes.
  assign is_digit = (c >= ast_pkg::C_DIGIT_0) && (c <= ast_pkg::C_DIGIT_9);
  assign is_word  = is_digit ||
                    ((c >= ast_pkg::C_LOWER_A) && (c <= ast_pkg::C_LOWER_Z)) ||
                    ((c >= ast_pkg::C_UPPER_A) && (c <= ast_pkg::C_UPPER_Z)) ||
                    (c == ast_pkg::C_UNDERSCORE) || (c == ast_pkg::C_DOT);

  // Times-ten accumulate; the sum exceeds the maximum exactly when the
  // decimal value must saturate.
  assign digit = 4'(c - ast_pkg::C_DIGIT_0);
  assign prod  = (PRODB'(number_value) << 3) + (PRODB'(number_value) << 1) +
                 PRODB'(digit);

  // The pending word as a token.
  always_comb begin
    word_tok.kind        = all_digits ? ast_pkg::K_NUMBER : ast_pkg::K_NAME;
    word_tok.start_res   = word_start;
    word_tok.length      = word_length;
    word_tok.value       = all_digits ? number_value : '0;
    word_tok.last_of_run = 1'b0;
  end

  // Scan one character: next state and up to two tokens.
  always_comb begin
    position_next        = (position == POS_MAX) ? position : position + 1'b1;
    word_start_next      = word_start;
    word_length_next     = word_length;
    all_digits_next      = all_digits;
    number_value_next    = number_value;
    in_comment_next      = in_comment;
    halted_on_error_next = halted_on_error;
    word_emit            = 1'b0;
    tok_emit             = 1'b0;
    single_tok.kind        = ast_pkg::K_END;
    single_tok.start_res   = position;
    single_tok.length      = PB'(1);
    single_tok.value       = '0;
    single_tok.last_of_run = 1'b1;

    priority if (c == ast_pkg::C_EOT) begin
      word_emit            = !halted_on_error && (word_length != '0);
      tok_emit             = 1'b1;
      single_tok.length    = '0;
      position_next        = '0;
      word_start_next      = '0;
      word_length_next     = '0;
      all_digits_next      = 1'b1;
      number_value_next    = '0;
      in_comment_next      = 1'b0;
      halted_on_error_next = 1'b0;
    end else if (halted_on_error) begin
      // Everything up to end of text is dropped.
    end else if (in_comment) begin
      if (c == ast_pkg::C_NEWLINE) begin
        in_comment_next = 1'b0;
        tok_emit        = 1'b1;
        single_tok.kind = ast_pkg::K_NEWLINE;
      end
    end else if (is_word) begin
      if (word_length == '0) begin
        word_start_next = position;
      end
      if (word_length != POS_MAX) begin
        word_length_next = word_length + 1'b1;
      end
      if (is_digit) begin
        number_value_next = (prod > PRODB'(VAL_MAX)) ? VAL_MAX : prod[VB-1:0];
      end else begin
        all_digits_next = 1'b0;
      end
    end else begin
      word_emit         = (word_length != '0);
      word_start_next   = '0;
      word_length_next  = '0;
      all_digits_next   = 1'b1;
      number_value_next = '0;
      unique case (c)
        ast_pkg::C_COLON: begin
          tok_emit = 1'b1;
          single_tok.kind = ast_pkg::K_COLON;
        end
        ast_pkg::C_COMMA: begin
          tok_emit = 1'b1;
          single_tok.kind = ast_pkg::K_COMMA;
        end
        ast_pkg::C_LBRACKET: begin
          tok_emit = 1'b1;
          single_tok.kind = ast_pkg::K_LBRACKET;
        end
        ast_pkg::C_RBRACKET: begin
          tok_emit = 1'b1;
          single_tok.kind = ast_pkg::K_RBRACKET;
        end
        ast_pkg::C_NEWLINE: begin
          tok_emit = 1'b1;
          single_tok.kind = ast_pkg::K_NEWLINE;
        end
        ast_pkg::C_SEMICOLON: begin
          in_comment_next = 1'b1;
        end
        ast_pkg::C_SPACE, ast_pkg::C_TAB, ast_pkg::C_CR,
        ast_pkg::C_VTAB, ast_pkg::C_FORMFEED: begin
          // Whitespace is skipped.
        end
        default: begin
          tok_emit             = 1'b1;
          single_tok.kind      = ast_pkg::K_ERROR;
          halted_on_error_next = 1'b1;
        end
      endcase
    end
  end

  // Order the tokens: the pending word always goes first.
  always_comb begin
    entry0             = word_emit ? word_tok : single_tok;
    entry0.last_of_run = !(word_emit && tok_emit);
    entry1             = single_tok;
    n_wr               = 2'(word_emit) + 2'(tok_emit);
  end

  // Scanning state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      position        <= '0;
      word_start      <= '0;
      word_length     <= '0;
      all_digits      <= 1'b1;
      number_value    <= '0;
      in_comment      <= 1'b0;
      halted_on_error <= 1'b0;
    end else if (accept) begin
      position        <= position_next;
      word_start      <= word_start_next;
      word_length     <= word_length_next;
      all_digits      <= all_digits_next;
      number_value    <= number_value_next;
      in_comment      <= in_comment_next;
      halted_on_error <= halted_on_error_next;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (accept && (n_wr != 2'd0)) begin
      queue[wr_ptr] <= entry0;
    end
    if (accept && (n_wr == 2'd2)) begin
      queue[wr_ptr + 1'b1] <= entry1;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + QPTRB'(n_wr);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (accept ? QCNTB'(n_wr) : '0) - QCNTB'(pop);
    end
  end

  // Head of the queue drives the token channel.
  assign tokens.valid       = (count != '0);
  assign tokens.kind        = queue[rd_ptr].kind;
  assign tokens.start_res   = queue[rd_ptr].start_res;
  assign tokens.length      = queue[rd_ptr].length;
  assign tokens.value       = queue[rd_ptr].value;
  assign tokens.last_of_run = queue[rd_ptr].last_of_run;

endmodule
